/* rtl/core/ktil_pkg.sv */
package ktil_pkg;
  localparam int MAX_ROWS_DEF = 256;
  localparam logic [16:0] PROB_ONE = 17'd65536;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_SINGLE  = 4'd0,
    ST_CLAMP_L = 4'd1,
    ST_CLAMP_H = 4'd2,
    ST_INTERP  = 4'd3,
    ST_NOMATCH = 4'd4,
    ST_EMPTY   = 4'd5,
    ST_LOADED  = 4'd6,
    ST_BADPROB = 4'd7,
    ST_FULL    = 4'd8,
    ST_CLEARED = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN1, S_SCAN2, S_FETCH, S_CAPT, S_DIV, S_SUM, S_NORM, S_OUT
  } fsm_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  material_code;
    logic [14:0] miller_indices;
    logic [23:0] energy;
    logic signed [31:0] angle_offset;
    logic [30:0] bragg_angle;
    logic [15:0] mosaic_width;
    logic [15:0] crystal_thickness;
    logic [16:0] prob_diffract;
    logic [16:0] prob_absorb;
    logic [16:0] prob_transmit;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [23:0] chosen_energy;
    logic signed [31:0] result_offset;
    logic [30:0] result_bragg;
    logic [15:0] result_mosaic;
    logic [15:0] result_thickness;
    logic [16:0] out_diffract;
    logic [16:0] out_absorb;
    logic [16:0] out_transmit;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

/* rtl/core/ktil_ram.sv */
module ktil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/ktil_div.sv */
// unsigned restoring divider, one quotient bit per cycle
module ktil_div import ktil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [34:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[63]} - {2'b00, den_r};
    if (ctl_i.start) begin
      quo_nxt = num_i;
      rem_nxt = '0;
      den_nxt = den_i;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!trial[34]) begin
        rem_nxt = trial[33:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[32:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy_o = (cnt_r != 7'd0) || ctl_i.start;
  assign quo_o  = quo_r;
endmodule

/* rtl/core/keyed_table_interpolating_lookup.sv */
// Keyed row table with nearest-energy lookup and linear interpolation in
// angle offset. One item is taken at a time. Load and clear give their result
// the cycle after the transfer. A lookup takes two passes over the stored
// rows, one memory read a row each, then a fetch of the chosen row. An
// interpolated result fetches a second row and adds up to nine sequential
// divisions in the shared divider (six for the interpolation, three for the
// renormalisation). Rows are held in a single-port-read RAM; nothing is
// cleared at reset beyond the row count.
module keyed_table_interpolating_lookup import ktil_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int RW = 43 + 32 + 31 + 32 + 51;

  fsm_t state_r, state_nxt;
  in_item_t req_r, req_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic rvld_r, rvld_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;

  logic found_r, found_nxt;
  logic [23:0] best_e_r, best_e_nxt, best_d_r, best_d_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic hlo_r, hlo_nxt, hhi_r, hhi_nxt, hlb_r, hlb_nxt, hub_r, hub_nxt;
  logic [AW-1:0] imin_r, imin_nxt, imax_r, imax_nxt, ilb_r, ilb_nxt, iub_r, iub_nxt;
  logic signed [31:0] omin_r, omin_nxt, omax_r, omax_nxt, olb_r, olb_nxt, oub_r, oub_nxt;
  logic [RW-1:0] lrow_r, lrow_nxt, urow_r, urow_nxt;
  logic fsel_r, fsel_nxt;
  logic [2:0] dstep_r, dstep_nxt;
  logic dstarted_r, dstarted_nxt;
  logic [31:0] lres_r [6];
  logic [31:0] lres_nxt [6];
  logic [18:0] psum_r, psum_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  ktil_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_rows (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  div_ctl_t div_ctl;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;
  logic div_busy;

  ktil_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl_i(div_ctl), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  // row fields: key(43) off(32) bragg(31) geo(32) prob(51)
  logic [18:0] r_key;
  logic [23:0] r_e;
  logic signed [31:0] r_off;
  assign r_key = ram_rdata[RW-1 -: 19];
  assign r_e   = ram_rdata[RW-20 -: 24];
  assign r_off = ram_rdata[RW-44 -: 32];

  logic [18:0] q_key;
  assign q_key = {req_r.material_code, req_r.miller_indices};
  logic [23:0] r_d;
  assign r_d = (r_e > req_r.energy) ? r_e - req_r.energy : req_r.energy - r_e;

  logic [18:0] in_psum;
  logic [18:0] in_dev;
  assign in_psum = {2'b0, in_data.prob_diffract} + {2'b0, in_data.prob_absorb}
                 + {2'b0, in_data.prob_transmit};
  assign in_dev = (in_psum > {2'b0, PROB_ONE}) ? in_psum - {2'b0, PROB_ONE}
                                               : {2'b0, PROB_ONE} - in_psum;

  // field of row by step: 0 bragg,1 mosaic,2 thick,3..5 probs
  function automatic logic [31:0] fld(input logic [RW-1:0] r, input logic [2:0] s);
    logic [31:0] v;
    v = '0;
    case (s)
      3'd0: v = {1'b0, r[113:83]};
      3'd1: v = {16'd0, r[82:67]};
      3'd2: v = {16'd0, r[66:51]};
      3'd3: v = {15'd0, r[50:34]};
      3'd4: v = {15'd0, r[33:17]};
      3'd5: v = {15'd0, r[16:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [31:0] fa, fb;
  logic [32:0] fdmag;
  logic fneg;
  logic [32:0] xnum, xden;
  assign xnum = 33'(signed'(req_r.angle_offset)) - 33'(signed'(olb_r));
  assign xden = 33'(signed'(oub_r)) - 33'(signed'(olb_r));

  always_comb begin
    fa = fld(lrow_r, dstep_r);
    fb = fld(urow_r, dstep_r);
    fneg = fb < fa;
    fdmag = fneg ? {1'b0, fa - fb} : {1'b0, fb - fa};
  end

  logic [32:0] dnum_lerp;
  assign dnum_lerp = xnum;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    rvld_nxt = 1'b0;
    ridx_nxt = ridx_r;
    found_nxt = found_r; best_e_nxt = best_e_r; best_d_nxt = best_d_r;
    n_nxt = n_r;
    hlo_nxt = hlo_r; hhi_nxt = hhi_r; hlb_nxt = hlb_r; hub_nxt = hub_r;
    imin_nxt = imin_r; imax_nxt = imax_r; ilb_nxt = ilb_r; iub_nxt = iub_r;
    omin_nxt = omin_r; omax_nxt = omax_r; olb_nxt = olb_r; oub_nxt = oub_r;
    lrow_nxt = lrow_r; urow_nxt = urow_r; fsel_nxt = fsel_r;
    dstep_nxt = dstep_r; dstarted_nxt = dstarted_r;
    lres_nxt = lres_r; psum_nxt = psum_r;
    ram_we = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = {in_data.material_code, in_data.miller_indices, in_data.energy,
                 in_data.angle_offset, in_data.bragg_angle, in_data.mosaic_width,
                 in_data.crystal_thickness, in_data.prob_diffract,
                 in_data.prob_absorb, in_data.prob_transmit};
    ram_raddr = idx_r[AW-1:0];
    div_ctl = '0;
    div_num = '0;
    div_den = '0;
    in_stall = 1'b1;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (in_valid && !in_stall) begin
          req_nxt = in_data;
          res_nxt = '0;
          case (mode_t'(in_data.mode))
            MODE_LOAD: begin
              out_valid_nxt = 1'b1;
              if (in_dev > 19'd2) res_nxt.status = ST_BADPROB;
              else if (count_r >= CW'(MAX_ROWS)) res_nxt.status = ST_FULL;
              else begin
                ram_we = 1'b1;
                count_nxt = count_r + 1'b1;
                res_nxt.status = ST_LOADED;
              end
            end
            MODE_CLEAR: begin
              out_valid_nxt = 1'b1;
              count_nxt = '0;
              res_nxt.status = ST_CLEARED;
            end
            MODE_LOOKUP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt.status = ST_EMPTY;
              end else begin
                found_nxt = 1'b0;
                idx_nxt = '0;
                state_nxt = S_SCAN1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN1, S_SCAN2: begin
        if (rvld_r && r_key == q_key) begin
          if (state_r == S_SCAN1) begin
            if (!found_r || r_d < best_d_r || (r_d == best_d_r && r_e < best_e_r)) begin
              found_nxt = 1'b1; best_e_nxt = r_e; best_d_nxt = r_d;
            end
          end else if (r_e == best_e_r) begin
            n_nxt = n_r + 1'b1;
            if (!hlo_r || r_off < omin_r) begin
              hlo_nxt = 1'b1; imin_nxt = ridx_r; omin_nxt = r_off;
            end
            if (!hhi_r || r_off > omax_r) begin
              hhi_nxt = 1'b1; imax_nxt = ridx_r; omax_nxt = r_off;
            end
            if (r_off < req_r.angle_offset && (!hlb_r || r_off > olb_r)) begin
              hlb_nxt = 1'b1; ilb_nxt = ridx_r; olb_nxt = r_off;
            end
            if (r_off >= req_r.angle_offset && (!hub_r || r_off < oub_r)) begin
              hub_nxt = 1'b1; iub_nxt = ridx_r; oub_nxt = r_off;
            end
          end
        end
        if (idx_r < count_r) begin
          rvld_nxt = 1'b1;
          ridx_nxt = idx_r[AW-1:0];
          idx_nxt = idx_r + 1'b1;
        end else if (!rvld_r) begin
          if (state_r == S_SCAN1) begin
            if (!found_nxt) begin
              res_nxt.status = ST_NOMATCH;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = '0;
              n_nxt = '0;
              hlo_nxt = 1'b0; hhi_nxt = 1'b0; hlb_nxt = 1'b0; hub_nxt = 1'b0;
              state_nxt = S_SCAN2;
            end
          end else begin
            fsel_nxt = 1'b0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (n_r == CW'(1) || req_r.angle_offset <= omin_r) ram_raddr = imin_r;
        else if (req_r.angle_offset >= omax_r) ram_raddr = imax_r;
        else ram_raddr = fsel_r ? iub_r : ilb_r;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        if (n_r == CW'(1) || req_r.angle_offset <= omin_r ||
            req_r.angle_offset >= omax_r) begin
          res_nxt.status = (n_r == CW'(1)) ? ST_SINGLE :
                           (req_r.angle_offset <= omin_r) ? ST_CLAMP_L : ST_CLAMP_H;
          res_nxt.chosen_energy = r_e;
          res_nxt.result_offset = r_off;
          res_nxt.result_bragg = ram_rdata[113:83];
          res_nxt.result_mosaic = ram_rdata[82:67];
          res_nxt.result_thickness = ram_rdata[66:51];
          res_nxt.out_diffract = ram_rdata[50:34];
          res_nxt.out_absorb = ram_rdata[33:17];
          res_nxt.out_transmit = ram_rdata[16:0];
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (!fsel_r) begin
          lrow_nxt = ram_rdata;
          fsel_nxt = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          urow_nxt = ram_rdata;
          dstep_nxt = '0;
          dstarted_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!dstarted_r) begin
          div_ctl.start = 1'b1;
          div_num = 64'(fdmag) * 64'(dnum_lerp);
          div_den = xden;
          dstarted_nxt = 1'b1;
        end else if (!div_busy) begin
          lres_nxt[dstep_r] = fneg ? fa - div_quo[31:0] : fa + div_quo[31:0];
          dstarted_nxt = 1'b0;
          if (dstep_r == 3'd5) state_nxt = S_SUM;
          else dstep_nxt = dstep_r + 3'd1;
        end
      end
      S_SUM: begin
        psum_nxt = 19'(lres_r[3]) + 19'(lres_r[4]) + 19'(lres_r[5]);
        dstep_nxt = 3'd3;
        dstarted_nxt = 1'b0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (psum_r == '0) state_nxt = S_OUT;
        else if (!dstarted_r) begin
          div_ctl.start = 1'b1;
          div_num = 64'({lres_r[dstep_r][16:0], 16'd0});
          div_den = 33'(psum_r);
          dstarted_nxt = 1'b1;
        end else if (!div_busy) begin
          lres_nxt[dstep_r] = div_quo[31:0];
          dstarted_nxt = 1'b0;
          if (dstep_r == 3'd5) state_nxt = S_OUT;
          else dstep_nxt = dstep_r + 3'd1;
        end
      end
      S_OUT: begin
        res_nxt.status = ST_INTERP;
        res_nxt.chosen_energy = best_e_r;
        res_nxt.result_offset = req_r.angle_offset;
        res_nxt.result_bragg = lres_r[0][30:0];
        res_nxt.result_mosaic = lres_r[1][15:0];
        res_nxt.result_thickness = lres_r[2][15:0];
        res_nxt.out_diffract = lres_r[3][16:0];
        res_nxt.out_absorb = lres_r[4][16:0];
        res_nxt.out_transmit = lres_r[5][16:0];
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r <= '0;
      rvld_r <= 1'b0;
      dstarted_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r <= count_nxt;
      rvld_r <= rvld_nxt;
      dstarted_r <= dstarted_nxt;
    end
    req_r <= req_nxt; res_r <= res_nxt; idx_r <= idx_nxt; ridx_r <= ridx_nxt;
    found_r <= found_nxt; best_e_r <= best_e_nxt; best_d_r <= best_d_nxt; n_r <= n_nxt;
    hlo_r <= hlo_nxt; hhi_r <= hhi_nxt; hlb_r <= hlb_nxt; hub_r <= hub_nxt;
    imin_r <= imin_nxt; imax_r <= imax_nxt; ilb_r <= ilb_nxt; iub_r <= iub_nxt;
    omin_r <= omin_nxt; omax_r <= omax_nxt; olb_r <= olb_nxt; oub_r <= oub_nxt;
    lrow_r <= lrow_nxt; urow_r <= urow_nxt; fsel_r <= fsel_nxt; dstep_r <= dstep_nxt;
    lres_r <= lres_nxt; psum_r <= psum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = res_r;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ROWS)) else $error("row count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r)) else $error("result lost");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE) else $error("write during lookup");
`endif
endmodule
